// ----- design/bmcd_pkg.sv -----
// ---------------------------------------------------------------------------
// bmcd_pkg: shared types and constants of the binary map corner detector
// Register indexes, field widths, queue sizing and the corner class record.
// ---------------------------------------------------------------------------
package bmcd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // field widths
  localparam int PIX_W    = 24;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // corner kinds and places
  localparam logic       KIND_INNER = 1'b0;
  localparam logic       KIND_OUTER = 1'b1;
  localparam logic [1:0] PLACE_LEFT_ABOVE  = 2'd0;
  localparam logic [1:0] PLACE_RIGHT_ABOVE = 2'd1;
  localparam logic [1:0] PLACE_LEFT_BELOW  = 2'd2;
  localparam logic [1:0] PLACE_RIGHT_BELOW = 2'd3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified window: bit i of mask is place i
  typedef struct packed {
    logic [3:0] mask;
    logic       kind;
  } class_t;

  localparam int CLASS_W = $bits(class_t);

endpackage

// ----- design/bmcd_ram.sv -----
// ---------------------------------------------------------------------------
// bmcd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-old).
// ---------------------------------------------------------------------------
module bmcd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bmcd_fifo.sv -----
// ---------------------------------------------------------------------------
// bmcd_fifo: short queue of classified corner windows
// Flip-flop storage, push and pop in the same cycle, head shown directly.
// ---------------------------------------------------------------------------
module bmcd_fifo #(
  parameter int WIDTH = 27
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [WIDTH-1:0]           head_data,
  output logic [bmcd_pkg::QCNT_W-1:0] count
);

  localparam int DEPTH = bmcd_pkg::QUEUE_DEPTH;
  localparam int PW    = bmcd_pkg::QPTR_W;
  localparam int CW    = bmcd_pkg::QCNT_W;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CW'(DEPTH))
    else $error("corner queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("corner queue underflow");

endmodule

// ----- design/bmcd_front.sv -----
// ---------------------------------------------------------------------------
// bmcd_front: pixel intake, line store, 3x3 window and corner classification
// Stage A tracks position and reads the line store; stage B closes the
// window, writes the line store back and pushes corner windows to the queue.
// ---------------------------------------------------------------------------
module bmcd_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel channel
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [bmcd_pkg::PIX_W-1:0]     pixel_color,
  input  logic                           frame_start,
  // configuration
  input  logic [bmcd_pkg::PIX_W-1:0]     map_color,
  input  logic [bmcd_pkg::WIDTH_W-1:0]   image_width,
  input  logic [bmcd_pkg::HEIGHT_W-1:0]  image_height,
  // queue side
  input  logic [bmcd_pkg::QCNT_W-1:0]    queue_count,
  output logic                           push,
  output logic [$clog2(MAX_COLS)-1:0]    push_col,
  output logic [$clog2(MAX_ROWS)-1:0]    push_row,
  output bmcd_pkg::class_t               push_cls
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int XW = 18;   // holds clamp bounds and both size registers
  localparam int QW = bmcd_pkg::QCNT_W + 1;

  // effective frame size, clamped to [3, MAX]
  logic [XW-1:0] wid_x, hgt_x, wid_eff, hgt_eff;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;

  assign wid_x = XW'(image_width);
  assign hgt_x = XW'(image_height);

  always_comb begin
    if (wid_x < XW'(3))             wid_eff = XW'(3);
    else if (wid_x > XW'(MAX_COLS)) wid_eff = XW'(MAX_COLS);
    else                            wid_eff = wid_x;
    if (hgt_x < XW'(3))             hgt_eff = XW'(3);
    else if (hgt_x > XW'(MAX_ROWS)) hgt_eff = XW'(MAX_ROWS);
    else                            hgt_eff = hgt_x;
  end

  assign col_last = CW'(wid_eff - XW'(1));
  assign row_last = RW'(hgt_eff - XW'(1));

  // ---------------- stage A ----------------
  logic          accept;
  logic [CW-1:0] col_pos, col_a;
  logic [RW-1:0] row_pos, row_a;
  logic          match_a;

  // stage B registers (declared early for the bypass compare)
  logic          b_valid;
  logic [CW-1:0] b_col;
  logic [RW-1:0] b_row;
  logic          b_bot;
  logic          byp_hit;
  logic [1:0]    byp_data;
  logic [1:0]    b_wdata;

  // room for this beat plus the one in stage B
  assign pixel_stall = ({1'b0, queue_count} + QW'(b_valid)) >= QW'(bmcd_pkg::QUEUE_DEPTH);
  assign accept      = pixel_valid && !pixel_stall;

  assign col_a   = frame_start ? '0 : col_pos;
  assign row_a   = frame_start ? '0 : row_pos;
  assign match_a = (pixel_color == map_color);

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_a >= col_last) begin
        col_pos <= '0;
        row_pos <= (row_a >= row_last) ? '0 : row_a + RW'(1);
      end else begin
        col_pos <= col_a + CW'(1);
        row_pos <= row_a;
      end
    end
  end

  // hand-over to stage B; catch a read of the column stage B is writing
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col    <= col_a;
      b_row    <= row_a;
      b_bot    <= match_a;
      byp_hit  <= b_valid && (b_col == col_a);
      byp_data <= b_wdata;
    end
  end

  // line store: bit 0 is row r-1, bit 1 is row r-2
  logic [1:0] ram_rdata;

  bmcd_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (col_a),
    .rdata (ram_rdata)
  );

  // ---------------- stage B ----------------
  logic [1:0] word_b;
  logic       top_b, mid_b;
  logic [5:0] win;

  assign word_b  = byp_hit ? byp_data : ram_rdata;
  assign mid_b   = word_b[0];
  assign top_b   = word_b[1];
  assign b_wdata = {mid_b, b_bot};

  // window: bits 0..2 column c-2, bits 3..5 column c-1 (top, mid, bottom)
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_valid) begin
      win <= {b_bot, mid_b, top_b, win[5:3]};
    end
  end

  // neighbors of the center
  logic al, le, bl, ab, be, ar, ri, br;
  logic judge, no_edge;
  logic [3:0] inner, outer;

  assign al = win[0];
  assign le = win[1];
  assign bl = win[2];
  assign ab = win[3];
  assign be = win[5];
  assign ar = top_b;
  assign ri = mid_b;
  assign br = b_bot;

  assign judge   = (b_row >= RW'(2)) && (b_col >= CW'(2)) && !win[4];
  assign no_edge = !(ab || be || le || ri);
  assign inner   = {be & ri, be & le, ab & ri, ab & le};
  assign outer   = no_edge ? {br, bl, ar, al} : 4'b0000;

  assign push_cls.mask = inner | outer;
  assign push_cls.kind = no_edge ? bmcd_pkg::KIND_OUTER : bmcd_pkg::KIND_INNER;
  assign push_col      = b_col - CW'(1);
  assign push_row      = b_row - RW'(1);
  assign push          = b_valid && judge && (push_cls.mask != 4'b0000);

endmodule

// ----- design/bmcd_back.sv -----
// ---------------------------------------------------------------------------
// bmcd_back: corner beat generator
// Walks the place mask of the queue head, one corner beat per cycle while
// corner_stall is low, into an output register.
// ---------------------------------------------------------------------------
module bmcd_back #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  // queue side
  input  logic             head_valid,
  input  logic [COL_W-1:0] head_col,
  input  logic [ROW_W-1:0] head_row,
  input  bmcd_pkg::class_t head_cls,
  output logic             pop,
  // corner channel
  output logic             corner_valid,
  input  logic             corner_stall,
  output logic [COL_W-1:0] corner_col,
  output logic [ROW_W-1:0] corner_row,
  output logic             corner_kind,
  output logic [1:0]       corner_place,
  output logic             last_of_pixel
);

  logic [3:0] sent;
  logic [3:0] remaining, pick;
  logic [1:0] place;
  logic       last, load;

  // lowest place not yet sent
  assign remaining = head_cls.mask & ~sent;
  assign pick      = remaining & (~remaining + 4'd1);
  assign last      = (remaining & ~pick) == 4'b0000;
  assign load      = head_valid && (!corner_valid || !corner_stall);
  assign pop       = load && last;

  always_comb begin
    case (pick)
      4'b0001: place = bmcd_pkg::PLACE_LEFT_ABOVE;
      4'b0010: place = bmcd_pkg::PLACE_RIGHT_ABOVE;
      4'b0100: place = bmcd_pkg::PLACE_LEFT_BELOW;
      4'b1000: place = bmcd_pkg::PLACE_RIGHT_BELOW;
      default: place = bmcd_pkg::PLACE_LEFT_ABOVE;
    endcase
  end

  // progress through the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (load) begin
      sent <= last ? 4'b0000 : (sent | pick);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
    end else if (!corner_valid || !corner_stall) begin
      corner_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corner_col    <= head_col;
      corner_row    <= head_row;
      corner_kind   <= head_cls.kind;
      corner_place  <= place;
      last_of_pixel <= last;
    end
  end

  // a pixel's beats follow each other without a gap
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_stall && !last_of_pixel |=> corner_valid)
    else $error("gap inside a corner burst");

  // progress mask stays within the head entry
  a_sent_in_head: assert property (@(posedge clk) disable iff (rst)
    (head_valid && ((sent & ~head_cls.mask) == 4'b0000)) || (!head_valid && sent == 4'b0000))
    else $error("corner progress mask out of step with queue head");

endmodule

// ----- design/binary_map_corner_detector_unit.sv -----
// ---------------------------------------------------------------------------
// binary_map_corner_detector_unit: corner features of a binary map raster
// Compares each pixel with the map color and emits corner beats per window.
// ---------------------------------------------------------------------------
// Usage:
//   Pixel channel (pixel_valid / pixel_stall, pixel_color, frame_start) takes
//   one raster-order pixel per cycle unless stalled; frame_start restarts it.
//   Corner channel (corner_valid / corner_stall) gives zero to four beats per
//   pixel, in place order; last_of_pixel marks the final beat of a pixel.
//   Config port (cfg_write, cfg_index, cfg_data) writes map_color,
//   image_width and image_height; write only while the block is idle.
// Timing:
//   Throughput is one pixel per cycle while pixel_stall is low. A pixel that
//   completes a window passes stage B, the queue and the output register to
//   the corner channel. The beat generator sends one beat per cycle while
//   corner_stall is low; a 4-entry queue absorbs pixels with several corners,
//   and pixel_stall rises only when queue plus classification stage are full.
// Reset:
//   Position and window clear, registers return to color 0, 640 x 480. The
//   line store is not cleared; the first two rows of a frame refill it.
//   While corner_stall is high, the beat is held and the queue fills.
// ---------------------------------------------------------------------------
module binary_map_corner_detector_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel channel
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [bmcd_pkg::PIX_W-1:0]       pixel_color,
  input  logic                             frame_start,
  // corner channel
  output logic                             corner_valid,
  input  logic                             corner_stall,
  output logic [$clog2(MAX_COLS)-1:0]      corner_col,
  output logic [$clog2(MAX_ROWS)-1:0]      corner_row,
  output logic                             corner_kind,
  output logic [1:0]                       corner_place,
  output logic                             last_of_pixel,
  // configuration
  input  logic                             cfg_write,
  input  logic [bmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = CW + RW + bmcd_pkg::CLASS_W;

  // configuration registers
  logic [bmcd_pkg::PIX_W-1:0]    map_color;
  logic [bmcd_pkg::WIDTH_W-1:0]  image_width;
  logic [bmcd_pkg::HEIGHT_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_color    <= '0;
      image_width  <= bmcd_pkg::WIDTH_RST;
      image_height <= bmcd_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bmcd_pkg::REG_MAP_COLOR:    map_color    <= cfg_data[bmcd_pkg::PIX_W-1:0];
        bmcd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bmcd_pkg::WIDTH_W-1:0];
        bmcd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bmcd_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // front
  logic                        push;
  logic [CW-1:0]               push_col;
  logic [RW-1:0]               push_row;
  bmcd_pkg::class_t            push_cls;
  logic [bmcd_pkg::QCNT_W-1:0] queue_count;

  bmcd_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_color  (pixel_color),
    .frame_start  (frame_start),
    .map_color    (map_color),
    .image_width  (image_width),
    .image_height (image_height),
    .queue_count  (queue_count),
    .push         (push),
    .push_col     (push_col),
    .push_row     (push_row),
    .push_cls     (push_cls)
  );

  // queue
  logic          pop, head_valid;
  logic [EW-1:0] head_data;

  bmcd_fifo #(
    .WIDTH (EW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_col, push_row, push_cls}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (queue_count)
  );

  // back
  logic [CW-1:0]    head_col;
  logic [RW-1:0]    head_row;
  bmcd_pkg::class_t head_cls;

  assign head_col = head_data[EW-1 -: CW];
  assign head_row = head_data[RW + bmcd_pkg::CLASS_W - 1 -: RW];
  assign head_cls = head_data[bmcd_pkg::CLASS_W-1:0];

  bmcd_back #(
    .COL_W (CW),
    .ROW_W (RW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_col      (head_col),
    .head_row      (head_row),
    .head_cls      (head_cls),
    .pop           (pop),
    .corner_valid  (corner_valid),
    .corner_stall  (corner_stall),
    .corner_col    (corner_col),
    .corner_row    (corner_row),
    .corner_kind   (corner_kind),
    .corner_place  (corner_place),
    .last_of_pixel (last_of_pixel)
  );

endmodule

// ----- tb/binary_map_corner_detector_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// binary_map_corner_detector_unit_tb: self-checking bench of the corner detector
// Streams raster frames under several map colors and frame sizes, predicts the
// corner beats of every accepted pixel and compares each beat in order, with
// random gaps on the pixel side and random stalls on the corner side.
// ---------------------------------------------------------------------------
module binary_map_corner_detector_unit_tb;

  localparam int COLS          = 1024;
  localparam int ROWS          = 4096;
  localparam int SETTLE_CYCLES = 12;
  localparam int GAP_CAP       = 20;
  localparam int MAX_REPORTS   = 40;
  // limit set well above the time the slowest run takes
  localparam int RUN_LIMIT_NS  = 2_000_000;

  localparam logic [bmcd_pkg::PIX_W-1:0] DIR_MAP = 24'h3C5A96;
  localparam logic [3:0] NO_PLACES  = 4'b0000;
  localparam logic [3:0] ALL_PLACES = 4'b1111;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic        kind;
    logic [1:0]  place;
    logic        last;
  } corner_t;

  // one pixel beat; typed rows carry their corners, others use the predictor
  typedef struct packed {
    logic [bmcd_pkg::PIX_W-1:0] pix;
    logic                       fs;
    logic                       typed;
    logic                       kind;
    logic [3:0]                 places;
    logic [9:0]                 col;
    logic [11:0]                row;
  } pixel_row_t;

  // 3x3 frames: inner corners all round, then (wrapping without frame_start)
  // outer corners all round, then a frame restart in the middle of a row
  localparam pixel_row_t DIRECTED_ROWS [25] = '{
    '{DIR_MAP,    1'b1, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'hFFFFFF, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, ALL_PLACES, 10'd1, 12'd1},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'h000000, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'h000000, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'hFFFFFF, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'hBC5A96, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'h3C5A97, 1'b0, 1'b1, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b1, bmcd_pkg::KIND_OUTER, ALL_PLACES, 10'd1, 12'd1},
    '{24'h000000, 1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'hFFFFFF, 1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b1, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{24'h000000, 1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0},
    '{DIR_MAP,    1'b0, 1'b0, bmcd_pkg::KIND_INNER, NO_PLACES,  10'd0, 12'd0}
  };

  // DUT ports
  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            pixel_valid  = 1'b0;
  logic                            pixel_stall;
  logic [bmcd_pkg::PIX_W-1:0]      pixel_color  = '0;
  logic                            frame_start  = 1'b0;
  logic                            corner_valid;
  logic                            corner_stall = 1'b0;
  logic [9:0]                      corner_col;
  logic [11:0]                     corner_row;
  logic                            corner_kind;
  logic [1:0]                      corner_place;
  logic                            last_of_pixel;
  logic                            cfg_write    = 1'b0;
  logic [bmcd_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [bmcd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  // predictor state and register copies
  bit                            line_mid [COLS];
  bit                            line_top [COLS];
  bit [5:0]                      win_bits;
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  logic [bmcd_pkg::PIX_W-1:0]    map_q    = '0;
  logic [bmcd_pkg::WIDTH_W-1:0]  width_q  = bmcd_pkg::WIDTH_RST;
  logic [bmcd_pkg::HEIGHT_W-1:0] height_q = bmcd_pkg::HEIGHT_RST;

  corner_t               expected_corners [$];
  int                    mismatch_count;
  int                    send_idle_pct;
  int                    stall_pct;

  binary_map_corner_detector_unit #(
    .MAX_COLS(COLS),
    .MAX_ROWS(ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_color  (pixel_color),
    .frame_start  (frame_start),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner_col   (corner_col),
    .corner_row   (corner_row),
    .corner_kind  (corner_kind),
    .corner_place (corner_place),
    .last_of_pixel(last_of_pixel),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    corner_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("binary_map_corner_detector_unit_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t corner mismatch: %s", $time, what);
  endtask

  // advance the corner predictor by one pixel; mask bit i is place i
  function automatic void track_corners(input logic [bmcd_pkg::PIX_W-1:0] pix,
                                        input logic fs,
                                        output logic [9:0] col, output logic [11:0] row,
                                        output logic kind, output logic [3:0] mask);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit          top;
    bit          mid;
    bit          bot;
    bit          ab;
    bit          be;
    bit          le;
    bit          ri;
    w = width_q;
    if (w < 3) w = 3;
    else if (w > COLS) w = COLS;
    h = height_q;
    if (h < 3) h = 3;
    else if (h > ROWS) h = ROWS;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    if (c >= COLS) c = 0;

    // match bit enters the line stores, older rows move up
    bot = (pix == map_q);
    mid = line_mid[c];
    top = line_top[c];
    line_top[c] = mid;
    line_mid[c] = bot;

    col  = 10'(c - 1);
    row  = 12'(r - 1);
    kind = bmcd_pkg::KIND_INNER;
    mask = NO_PLACES;
    // judge the window centred one row up and one column left
    if (r >= 2 && c >= 2 && !win_bits[4]) begin
      ab = win_bits[3];
      be = win_bits[5];
      le = win_bits[1];
      ri = mid;
      mask[bmcd_pkg::PLACE_LEFT_ABOVE]  = ab && le;
      mask[bmcd_pkg::PLACE_RIGHT_ABOVE] = ab && ri;
      mask[bmcd_pkg::PLACE_LEFT_BELOW]  = be && le;
      mask[bmcd_pkg::PLACE_RIGHT_BELOW] = be && ri;
      if (!(ab || be || le || ri)) begin
        kind = bmcd_pkg::KIND_OUTER;
        mask[bmcd_pkg::PLACE_LEFT_ABOVE]  = win_bits[0];
        mask[bmcd_pkg::PLACE_RIGHT_ABOVE] = top;
        mask[bmcd_pkg::PLACE_LEFT_BELOW]  = win_bits[2];
        mask[bmcd_pkg::PLACE_RIGHT_BELOW] = bot;
      end
    end
    win_bits = {bot, mid, top, win_bits[5:3]};

    // raster position, wrapping at row and frame end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void queue_corners(input logic [9:0] col, input logic [11:0] row,
                                        input logic kind, input logic [3:0] mask);
    int      n;
    int      k;
    corner_t cb;
    n = $countones(mask);
    k = 0;
    for (int p = 0; p < 4; p++) begin
      if (mask[p]) begin
        k++;
        cb.col   = col;
        cb.row   = row;
        cb.kind  = kind;
        cb.place = 2'(p);
        cb.last  = (k == n);
        expected_corners = {expected_corners, cb};
      end
    end
  endfunction

  // drive one pixel beat, optionally after idle cycles, and wait for it to go in
  task automatic send_row(input pixel_row_t pr);
    int          gap;
    logic [9:0]  col;
    logic [11:0] row;
    logic        kind;
    logic [3:0]  mask;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_color <= pr.pix;
    frame_start <= pr.fs;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    track_corners(pr.pix, pr.fs, col, row, kind, mask);
    if (pr.typed) queue_corners(pr.col, pr.row, pr.kind, pr.places);
    else queue_corners(col, row, kind, mask);
  endtask

  task automatic write_reg(input logic [bmcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmcd_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bmcd_pkg::REG_MAP_COLOR:    map_q    = val[bmcd_pkg::PIX_W-1:0];
      bmcd_pkg::REG_IMAGE_WIDTH:  width_q  = val[bmcd_pkg::WIDTH_W-1:0];
      bmcd_pkg::REG_IMAGE_HEIGHT: height_q = val[bmcd_pkg::HEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 51;
        stall_pct     = 0;
      end
      IDLE_STALL: begin
        send_idle_pct = 0;
        stall_pct     = 51;
      end
      default: begin
        send_idle_pct = 37;
        stall_pct     = 37;
      end
    endcase
  endtask

  // wait for every predicted beat, then let pixels without corners flush
  task automatic drain_corners();
    pixel_valid <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // half the pixels match the map, a quarter miss it by a single bit
  function automatic logic [bmcd_pkg::PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return map_q;
    if (roll < 75) return map_q ^ (bmcd_pkg::PIX_W'(1) << $urandom_range(bmcd_pkg::PIX_W - 1));
    return bmcd_pkg::PIX_W'($urandom());
  endfunction

  task automatic run_phase(input logic [bmcd_pkg::PIX_W-1:0] map_val,
                           input logic [bmcd_pkg::WIDTH_W-1:0] w,
                           input logic [bmcd_pkg::HEIGHT_W-1:0] h, input int count,
                           input idle_mode_t mode);
    pixel_row_t pr;
    drain_corners();
    write_reg(bmcd_pkg::REG_MAP_COLOR, bmcd_pkg::CFG_DATA_W'(map_val));
    write_reg(bmcd_pkg::REG_IMAGE_WIDTH, bmcd_pkg::CFG_DATA_W'(w));
    write_reg(bmcd_pkg::REG_IMAGE_HEIGHT, bmcd_pkg::CFG_DATA_W'(h));
    set_idling(mode);
    // every phase opens a new frame so the line stores are refilled first
    for (int i = 0; i < count; i++) begin
      pr     = '0;
      pr.pix = pick_pixel();
      pr.fs  = (i == 0) || ($urandom_range(99) < 2);
      send_row(pr);
    end
  endtask

  // compare each corner beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    corner_t want;
    if (!rst && corner_valid === 1'b1 && corner_stall === 1'b0) begin
      if (expected_corners.size() == 0) begin
        report_mismatch($sformatf("beat with none expected, col %0d row %0d",
                                  corner_col, corner_row));
      end else begin
        want = expected_corners.pop_front();
        if (corner_col !== want.col)
          report_mismatch($sformatf("col %0d, want %0d", corner_col, want.col));
        if (corner_row !== want.row)
          report_mismatch($sformatf("row %0d, want %0d", corner_row, want.row));
        if (corner_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d at (%0d,%0d)",
                                    corner_kind, want.kind, want.col, want.row));
        if (corner_place !== want.place)
          report_mismatch($sformatf("place %0d, want %0d at (%0d,%0d)",
                                    corner_place, want.place, want.col, want.row));
        if (last_of_pixel !== want.last)
          report_mismatch($sformatf("last %0d, want %0d at (%0d,%0d)",
                                    last_of_pixel, want.last, want.col, want.row));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed 3x3 frames
    set_idling(IDLE_BOTH);
    write_reg(bmcd_pkg::REG_MAP_COLOR, bmcd_pkg::CFG_DATA_W'(DIR_MAP));
    write_reg(bmcd_pkg::REG_IMAGE_WIDTH, bmcd_pkg::CFG_DATA_W'(3));
    write_reg(bmcd_pkg::REG_IMAGE_HEIGHT, bmcd_pkg::CFG_DATA_W'(3));
    foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);

    // random frames; out-of-range sizes clamp
    run_phase(bmcd_pkg::PIX_W'($urandom()), 11'd3,    13'd3,    40, IDLE_NONE);
    run_phase(24'hFFFFFF,                   11'd5,    13'd4,    40, IDLE_SEND);
    run_phase(24'h000000,                   11'd0,    13'd8191, 40, IDLE_STALL);
    run_phase(bmcd_pkg::PIX_W'($urandom()), 11'd1025, 13'd3,    40, IDLE_BOTH);
    run_phase(bmcd_pkg::PIX_W'($urandom()), 11'd7,    13'd2,    40, IDLE_NONE);
    run_phase(bmcd_pkg::PIX_W'($urandom()), 11'd4,    13'd4096, 50, IDLE_SEND);
    run_phase(bmcd_pkg::PIX_W'($urandom()), 11'd6,    13'd5,    40, IDLE_STALL);
    drain_corners();

    if (mismatch_count == 0) begin
      $display("binary_map_corner_detector_unit_tb passed");
    end else begin
      $display("binary_map_corner_detector_unit_tb failed");
    end
    $finish;
  end

endmodule
